[rtl/s3tc_block_decoder_core_macros.svh]
// assertion macros used by the s3tc block decoder checker
// no dependencies; take in by include where assertions are written
`ifndef S3TC_BLOCK_DECODER_CORE_MACROS_SVH
`define S3TC_BLOCK_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define S3TC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define S3TC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/s3tc_pkg.sv]
// types and constants for the s3tc block decoder
// no dependencies; used by the core and its checker
package s3tc_pkg;

  typedef enum logic [1:0] {
    FmtDxt1      = 2'd0,
    FmtDxt1Alpha = 2'd1,
    FmtDxt3      = 2'd2,
    FmtDxt5      = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    ColDirect = 2'd0,
    ColDiv2   = 2'd1,
    ColDiv3   = 2'd2
  } col_op_e;

  typedef enum logic [1:0] {
    AlpDirect = 2'd0,
    AlpDiv5   = 2'd1,
    AlpDiv7   = 2'd2
  } alp_op_e;

  localparam int unsigned TexelIdxW = 4;
  localparam logic [TexelIdxW-1:0] LastTexel = 4'd15;

  // color index codes
  localparam logic [1:0] CodeEp0  = 2'd0;
  localparam logic [1:0] CodeEp1  = 2'd1;
  localparam logic [1:0] CodeMixA = 2'd2;
  localparam logic [1:0] CodeMixB = 2'd3;

  // dxt5 alpha codes with fixed meaning
  localparam logic [2:0] ACodeA0    = 3'd0;
  localparam logic [2:0] ACodeA1    = 3'd1;
  localparam logic [2:0] ACodeZero  = 3'd6;
  localparam logic [2:0] ACodeFull  = 3'd7;

  // reciprocal multipliers for truncating division by 3, 5 and 7
  localparam int unsigned Recip3 = 683;
  localparam int unsigned Shift3 = 11;
  localparam int unsigned Recip5 = 3277;
  localparam int unsigned Shift5 = 14;
  localparam int unsigned Recip7 = 2341;
  localparam int unsigned Shift7 = 14;

endpackage

[rtl/s3tc_block_decoder_core.sv]
// s3tc block decoder: one texel word per cycle while out_stall_i is low,
// 16 words per block in raster order.
// block rate is set by the single texel output port;
// the next block is taken in the cycle the sixteenth texel is issued.
// pipeline: block register, texel select, numerator, reciprocal divide/output.
// async active-low reset clears valid bits, texel counter and mode_q.
module s3tc_block_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [63:0]                   alpha_part_i,
  input  logic [63:0]                   color_part_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [s3tc_pkg::TexelIdxW-1:0] texel_index_o,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  output logic [7:0]                    alpha_o,
  output logic                          last_texel_o
);
  import s3tc_pkg::*;

  typedef struct packed {
    logic [TexelIdxW-1:0] idx;
    logic [1:0]           code;
    logic                 four;
    logic [2:0][7:0]      e0;
    logic [2:0][7:0]      e1;
    logic [2:0]           acode;
    logic [3:0]           nib;
    logic [7:0]           a0;
    logic [7:0]           a1;
  } sel_t;

  typedef struct packed {
    logic [TexelIdxW-1:0] idx;
    logic [2:0][9:0]      num;
    col_op_e              col_op;
    logic [10:0]          anum;
    alp_op_e              alp_op;
  } num_t;

  typedef struct packed {
    logic [TexelIdxW-1:0] idx;
    logic [2:0][7:0]      rgb;
    logic [7:0]           a;
  } texel_t;

  fmt_e mode_q;

  // block register and texel counter
  logic                 blk_v_q, blk_v_d;
  logic [63:0]          alpha_q, color_q;
  logic [TexelIdxW-1:0] cnt_q, cnt_d;

  logic sel_v_q, num_v_q, out_v_q;
  sel_t   sel_q, sel_d;
  num_t   num_q, num_d;
  texel_t out_q, out_d;

  logic en_out, en_num, en_sel, issue, blk_done, in_acc;

  assign en_out   = !out_v_q || !out_stall_i;
  assign en_num   = !num_v_q || en_out;
  assign en_sel   = !sel_v_q || en_num;
  assign issue    = blk_v_q && en_sel;
  assign blk_done = issue && (cnt_q == LastTexel);
  assign in_stall_o = blk_v_q && !blk_done;
  assign in_acc   = in_valid_i && !in_stall_o;

  always_comb begin
    blk_v_d = blk_v_q;
    if (in_acc) begin
      blk_v_d = 1'b1;
    end else if (blk_done) begin
      blk_v_d = 1'b0;
    end
    cnt_d = issue ? cnt_q + 1'b1 : cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= FmtDxt1;
      blk_v_q <= 1'b0;
      cnt_q   <= '0;
      sel_v_q <= 1'b0;
      num_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= fmt_e'(cfg_wdata_i);
      end
      blk_v_q <= blk_v_d;
      cnt_q   <= cnt_d;
      if (en_sel) begin
        sel_v_q <= blk_v_q;
      end
      if (en_num) begin
        num_v_q <= sel_v_q;
      end
      if (en_out) begin
        out_v_q <= num_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      alpha_q <= alpha_part_i;
      color_q <= color_part_i;
    end
    if (en_sel) begin
      sel_q <= sel_d;
    end
    if (en_num) begin
      num_q <= num_d;
    end
    if (en_out) begin
      out_q <= out_d;
    end
  end

  // stage 1: pick this texel's codes and widen the 565 endpoints
  logic [15:0] c0, c1;
  logic [31:0] cidx;
  logic [47:0] aidx;
  logic [4:0]  cpos;
  logic [5:0]  apos, npos;

  always_comb begin
    c0   = color_q[15:0];
    c1   = color_q[31:16];
    cidx = color_q[63:32];
    aidx = alpha_q[63:16];
    cpos = {cnt_q, 1'b0};
    npos = {cnt_q, 2'b00};
    apos = 6'(cnt_q) * 6'd3;
    sel_d.idx   = cnt_q;
    sel_d.code  = cidx[cpos +: 2];
    sel_d.four  = (mode_q == FmtDxt3) || (mode_q == FmtDxt5) || (c0 > c1);
    sel_d.e0[0] = {c0[15:11], c0[15:13]};
    sel_d.e0[1] = {c0[10:5], c0[10:9]};
    sel_d.e0[2] = {c0[4:0], c0[4:2]};
    sel_d.e1[0] = {c1[15:11], c1[15:13]};
    sel_d.e1[1] = {c1[10:5], c1[10:9]};
    sel_d.e1[2] = {c1[4:0], c1[4:2]};
    sel_d.acode = aidx[apos +: 3];
    sel_d.nib   = alpha_q[npos +: 4];
    sel_d.a0    = alpha_q[7:0];
    sel_d.a1    = alpha_q[15:8];
  end

  // stage 2: palette numerators and the divide to apply
  logic [2:0] w0, w1;

  always_comb begin
    num_d.idx    = sel_q.idx;
    num_d.col_op = ColDirect;
    for (int k = 0; k < 3; k++) begin
      num_d.num[k] = '0;
    end
    case (sel_q.code)
      CodeEp0: begin
        for (int k = 0; k < 3; k++) num_d.num[k] = 10'(sel_q.e0[k]);
      end
      CodeEp1: begin
        for (int k = 0; k < 3; k++) num_d.num[k] = 10'(sel_q.e1[k]);
      end
      CodeMixA: begin
        num_d.col_op = sel_q.four ? ColDiv3 : ColDiv2;
        for (int k = 0; k < 3; k++) begin
          num_d.num[k] = sel_q.four ? {1'b0, sel_q.e0[k], 1'b0} + 10'(sel_q.e1[k])
                                    : 10'(sel_q.e0[k]) + 10'(sel_q.e1[k]);
        end
      end
      CodeMixB: begin
        // three-color block: black
        num_d.col_op = sel_q.four ? ColDiv3 : ColDirect;
        for (int k = 0; k < 3; k++) begin
          num_d.num[k] = sel_q.four ? 10'(sel_q.e0[k]) + {1'b0, sel_q.e1[k], 1'b0} : '0;
        end
      end
      default: ;
    endcase

    w1 = sel_q.acode - 3'd1;
    w0 = (sel_q.a0 > sel_q.a1) ? 3'd0 - sel_q.acode : 3'd6 - sel_q.acode;
    num_d.alp_op = AlpDirect;
    num_d.anum   = 11'd255;
    case (mode_q)
      FmtDxt1Alpha: begin
        if (sel_q.code == CodeMixB && !sel_q.four) num_d.anum = '0;
      end
      FmtDxt3: begin
        num_d.anum = 11'({sel_q.nib, sel_q.nib});
      end
      FmtDxt5: begin
        if (sel_q.acode == ACodeA0) begin
          num_d.anum = 11'(sel_q.a0);
        end else if (sel_q.acode == ACodeA1) begin
          num_d.anum = 11'(sel_q.a1);
        end else if (sel_q.a0 > sel_q.a1 ||
                     (sel_q.acode != ACodeZero && sel_q.acode != ACodeFull)) begin
          // 8 - code wraps to 3 bits as 0 - code
          num_d.alp_op = (sel_q.a0 > sel_q.a1) ? AlpDiv7 : AlpDiv5;
          num_d.anum   = 11'(sel_q.a0) * 11'(w0) + 11'(sel_q.a1) * 11'(w1);
        end else if (sel_q.acode == ACodeZero) begin
          num_d.anum = '0;
        end
      end
      default: ;
    endcase
  end

  // stage 3: truncating divide by reciprocal multiply
  logic [2:0][19:0] prod3;
  logic [22:0]      prod5, prod7;

  always_comb begin
    out_d.idx = num_q.idx;
    for (int k = 0; k < 3; k++) begin
      prod3[k] = 20'(num_q.num[k]) * 20'(Recip3);
      case (num_q.col_op)
        ColDiv2: out_d.rgb[k] = num_q.num[k][8:1];
        ColDiv3: out_d.rgb[k] = prod3[k][Shift3 +: 8];
        default: out_d.rgb[k] = num_q.num[k][7:0];
      endcase
    end
    prod5 = 23'(num_q.anum) * 23'(Recip5);
    prod7 = 23'(num_q.anum) * 23'(Recip7);
    case (num_q.alp_op)
      AlpDiv5: out_d.a = prod5[Shift5 +: 8];
      AlpDiv7: out_d.a = prod7[Shift7 +: 8];
      default: out_d.a = num_q.anum[7:0];
    endcase
  end

  assign out_valid_o   = out_v_q;
  assign texel_index_o = out_q.idx;
  assign red_o         = out_q.rgb[0];
  assign green_o       = out_q.rgb[1];
  assign blue_o        = out_q.rgb[2];
  assign alpha_o       = out_q.a;
  assign last_texel_o  = (out_q.idx == LastTexel);

endmodule

[rtl/s3tc_chk.sv]
// port-level checker for s3tc_block_decoder_core, bound to s3tc_block_decoder_core
// depends on s3tc_pkg and s3tc_block_decoder_core_macros.svh
`include "s3tc_block_decoder_core_macros.svh"

module s3tc_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [s3tc_pkg::TexelIdxW-1:0] texel_index_o,
  input logic [7:0]                    alpha_o,
  input logic                          last_texel_o
);
  import s3tc_pkg::*;

  // a stalled word holds its texel
  `S3TC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(texel_index_o) && $stable(alpha_o), "stalled texel word changed")

  `S3TC_ASSERT_NOW(a_last, clk_i, rst_ni, out_valid_o, last_texel_o == (texel_index_o == LastTexel), "last flag does not match texel 15")

  // texels of a block leave in raster order
  `S3TC_ASSERT_NEXT(a_order, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_texel_o, !out_valid_o || texel_index_o == $past(texel_index_o) + 4'd1, "texel order broken")

  // a new block starts at texel 0
  `S3TC_ASSERT_NEXT(a_start, clk_i, rst_ni, out_valid_o && !out_stall_i && last_texel_o, !out_valid_o || texel_index_o == '0, "block does not start at texel 0")

endmodule

bind s3tc_block_decoder_core s3tc_chk u_s3tc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .texel_index_o (texel_index_o),
  .alpha_o       (alpha_o),
  .last_texel_o  (last_texel_o)
);
